@@ rtl/ppid_pkg.sv @@
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types and constants for the preset position PID lift controller.
// ----------------------------------------------------------------------------
package ppid_pkg;

   // Field widths
   localparam int GainW  = 24;                 // unsigned Q8.16 gains
   localparam int PosW   = 16;                 // position and targets
   localparam int ErrW   = PosW + 1;           // target - position
   localparam int DerW   = ErrW + 1;           // error - previous error
   localparam int SumW   = 32;                 // saturating integral
   localparam int VelW   = 9;                  // drive velocity
   localparam int FracW  = 16;                 // fraction bits of the gains
   localparam int AccW   = 58;                 // exact sum of the three products
   localparam int WholeW = AccW - FracW;
   localparam int VelLimit = 200;

   // Configuration port
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = GainW;

   // Stream payload widths, padded to whole bytes
   localparam int ReqDataW = 24;
   localparam int RspDataW = 16;

   // Register indexes
   typedef enum logic [CsrAddrW-1:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_I       = 3'd1,
      CSR_GAIN_D       = 3'd2,
      CSR_TARGET_HIGH  = 3'd3,
      CSR_TARGET_CARRY = 3'd4,
      CSR_TARGET_LOW   = 3'd5
   } csr_index_type;

   // Latched operating mode
   typedef enum logic [2:0] {
      MODE_NONE  = 3'd0,
      MODE_HIGH  = 3'd1,
      MODE_LOW   = 3'd2,
      MODE_CARRY = 3'd3,
      MODE_STOP  = 3'd4
   } mode_type;

   // Gains and preset targets
   typedef struct packed {
      logic [GainW-1:0]        gain_p;
      logic [GainW-1:0]        gain_i;
      logic [GainW-1:0]        gain_d;
      logic signed [PosW-1:0]  target_high;
      logic signed [PosW-1:0]  target_carry;
      logic signed [PosW-1:0]  target_low;
   } cfg_type;

   // One PID step: drive command and the updated loop state
   typedef struct packed {
      logic signed [VelW-1:0]  velocity;
      logic signed [SumW-1:0]  error_sum;
      logic signed [ErrW-1:0]  last_error;
   } pid_step_type;

endpackage

@@ rtl/preset_position_pid.sv @@
// ----------------------------------------------------------------------------
// preset_position_pid
// Preset position PID controller for a lift, one result per control tick.
// Throughput: one request per cycle unless a held result stalls the input;
// a request, its mode latch and the PID state update pass through a single
// stage between input and result register.
// Reset: mode returns to none, integral and previous error clear to zero,
// gains and targets reload their presets.
// ----------------------------------------------------------------------------
module preset_position_pid (
   input  logic                          clock,
   input  logic                          reset,
   // Request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [0] btn_up, [1] btn_down, [2] btn_left, [3] btn_right, [19:4] position
   input  logic [ppid_pkg::ReqDataW-1:0] req_tdata,
   // Result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [8:0] drive_velocity, [9] drive_enable, [12:10] active_mode
   output logic [ppid_pkg::RspDataW-1:0] rsp_tdata,
   // Configuration write port
   input  logic                          csr_we,
   input  logic [ppid_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [ppid_pkg::CsrDataW-1:0] csr_wdata
);
   import ppid_pkg::*;

   cfg_type                 cfg;
   pid_step_type            pid;

   logic                    in_valid_ff;
   logic [3:0]              in_btn_ff;
   logic signed [PosW-1:0]  in_pos_ff;

   mode_type                mode_ff;
   mode_type                mode_in;
   logic signed [SumW-1:0]  error_sum_ff;
   logic signed [ErrW-1:0]  last_error_ff;

   logic                    rsp_valid_ff;
   logic signed [VelW-1:0]  rsp_vel_ff;
   logic signed [VelW-1:0]  rsp_vel_in;
   logic                    rsp_en_ff;
   mode_type                rsp_mode_ff;

   logic                    advance;
   logic                    fire;
   logic                    pid_run;

   ppid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: the input stage drains whenever the result register is free
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Latch mode by button priority; hold it when no button is pressed
   always_comb begin
      if (in_btn_ff[0]) begin
         mode_in = MODE_HIGH;
      end else if (in_btn_ff[1]) begin
         mode_in = MODE_LOW;
      end else if (in_btn_ff[2]) begin
         mode_in = MODE_CARRY;
      end else if (in_btn_ff[3]) begin
         mode_in = MODE_STOP;
      end else begin
         mode_in = mode_ff;
      end
   end

   assign pid_run = (mode_in == MODE_HIGH) || (mode_in == MODE_LOW) ||
                    (mode_in == MODE_CARRY);

   ppid_pid u_pid (
      .cfg        (cfg),
      .mode       (mode_in),
      .position   (in_pos_ff),
      .error_sum  (error_sum_ff),
      .last_error (last_error_ff),
      .step       (pid)
   );

   assign rsp_vel_in = pid_run ? pid.velocity : '0;

   // Control state: valid flags, latched mode, PID loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_NONE;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            mode_ff <= mode_in;
            if (pid_run) begin
               error_sum_ff  <= pid.error_sum;
               last_error_ff <= pid.last_error;
            end
         end
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_btn_ff <= req_tdata[3:0];
         in_pos_ff <= req_tdata[4 +: PosW];
      end
   end

   // Capture the result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_vel_ff  <= rsp_vel_in;
         rsp_en_ff   <= (mode_in != MODE_NONE);
         rsp_mode_ff <= mode_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RspDataW - VelW - 4)'(0), rsp_mode_ff, rsp_en_ff, rsp_vel_ff};

   // Once a mode is latched it never returns to none
   a_mode_sticky: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_NONE) |=> (mode_ff != MODE_NONE))
      else $error("latched mode fell back to none");

   // Loop state only moves on a PID step
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(fire && pid_run) |=> ($stable(error_sum_ff) && $stable(last_error_ff)))
      else $error("PID state changed without a PID step");

   // Drive is zero outside the PID modes and within the limit inside them
   a_vel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_vel_ff <= VelW'(VelLimit)) &&
                        (rsp_vel_ff >= -VelW'(VelLimit)) &&
                        (((rsp_mode_ff != MODE_NONE) && (rsp_mode_ff != MODE_STOP)) ||
                         (rsp_vel_ff == '0))))
      else $error("drive velocity out of range for its mode");

   // The request side stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled with room downstream");

endmodule

@@ rtl/ppid_csr.sv @@
// ----------------------------------------------------------------------------
// ppid_csr
// Gain and preset target registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ppid_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ppid_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [ppid_pkg::CsrDataW-1:0] csr_wdata,
   output ppid_pkg::cfg_type             cfg
);
   import ppid_pkg::*;

   cfg_type cfg_ff;

   // Load reset presets, then take writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p       <= GainW'(32768);
         cfg_ff.gain_i       <= GainW'(66);
         cfg_ff.gain_d       <= GainW'(66);
         cfg_ff.target_high  <= PosW'(690);
         cfg_ff.target_carry <= PosW'(550);
         cfg_ff.target_low   <= PosW'(15);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_GAIN_P:       cfg_ff.gain_p       <= csr_wdata;
            CSR_GAIN_I:       cfg_ff.gain_i       <= csr_wdata;
            CSR_GAIN_D:       cfg_ff.gain_d       <= csr_wdata;
            CSR_TARGET_HIGH:  cfg_ff.target_high  <= csr_wdata[PosW-1:0];
            CSR_TARGET_CARRY: cfg_ff.target_carry <= csr_wdata[PosW-1:0];
            CSR_TARGET_LOW:   cfg_ff.target_low   <= csr_wdata[PosW-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/ppid_pid.sv @@
// ----------------------------------------------------------------------------
// ppid_pid
// One PID step: error, saturating integral, derivative, Q8.16 weighted sum,
// truncation toward zero and clamp to the drive velocity limit.
// ----------------------------------------------------------------------------
module ppid_pid (
   input  ppid_pkg::cfg_type                   cfg,
   input  ppid_pkg::mode_type                  mode,
   input  logic signed [ppid_pkg::PosW-1:0]    position,
   input  logic signed [ppid_pkg::SumW-1:0]    error_sum,
   input  logic signed [ppid_pkg::ErrW-1:0]    last_error,
   output ppid_pkg::pid_step_type              step
);
   import ppid_pkg::*;

   logic signed [PosW-1:0]     target;
   logic signed [ErrW-1:0]     err;
   logic signed [SumW:0]       sum_wide;
   logic signed [SumW-1:0]     sum_sat;
   logic signed [DerW-1:0]     deriv;
   logic signed [GainW:0]      gp_s;
   logic signed [GainW:0]      gi_s;
   logic signed [GainW:0]      gd_s;
   logic signed [GainW+ErrW:0] prod_p;
   logic signed [GainW+SumW:0] prod_i;
   logic signed [GainW+DerW:0] prod_d;
   logic signed [AccW-1:0]     acc;
   logic signed [AccW-1:0]     acc_bias;
   logic signed [WholeW-1:0]   whole;
   logic signed [VelW-1:0]     vel;

   // Pick the preset for the latched mode
   always_comb begin
      case (mode)
         MODE_HIGH:  target = cfg.target_high;
         MODE_LOW:   target = cfg.target_low;
         MODE_CARRY: target = cfg.target_carry;
         default:    target = cfg.target_high;
      endcase
   end

   // Error terms; clamp the integral to the signed 32-bit range
   assign err      = ErrW'(target) - ErrW'(position);
   assign sum_wide = (SumW+1)'(error_sum) + (SumW+1)'(err);
   assign deriv    = DerW'(err) - DerW'(last_error);

   always_comb begin
      if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SumW-1:0];
      end
   end

   // Weighted sum of the three terms, exact
   assign gp_s   = $signed({1'b0, cfg.gain_p});
   assign gi_s   = $signed({1'b0, cfg.gain_i});
   assign gd_s   = $signed({1'b0, cfg.gain_d});
   assign prod_p = gp_s * err;
   assign prod_i = gi_s * sum_sat;
   assign prod_d = gd_s * deriv;
   assign acc    = AccW'(prod_p) + AccW'(prod_i) + AccW'(prod_d);

   // Drop the fraction toward zero: bias negative values before the shift
   assign acc_bias = acc + (acc[AccW-1] ? AccW'({FracW{1'b1}}) : AccW'(0));
   assign whole    = WholeW'(acc_bias >>> FracW);

   // Clamp to the velocity limit
   always_comb begin
      if (whole > WholeW'(VelLimit)) begin
         vel = VelW'(VelLimit);
      end else if (whole < -WholeW'(VelLimit)) begin
         vel = -VelW'(VelLimit);
      end else begin
         vel = whole[VelW-1:0];
      end
   end

   assign step.velocity   = vel;
   assign step.error_sum  = sum_sat;
   assign step.last_error = err;

endmodule

@@ tb/sv/preset_position_pid_test.sv @@
// ----------------------------------------------------------------------------
// preset_position_pid_test
// Self-checking bench for the preset position PID lift controller. A directed
// table covers idle, stop, button priority and the position extremes. Random
// ticks then run under several gain and target settings, with bursty requests
// and a stalling result side. A short sweep at the widest error swings the
// integral up, down and back. Every result is checked against a typed value
// or a cycle-free model of the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module preset_position_pid_test;
   import ppid_pkg::*;

   typedef struct packed {
      logic signed [VelW-1:0] velocity;
      logic                   enable;
      mode_type               mode;
   } drive_cmd_type;

   typedef struct packed {
      logic [3:0]             buttons;
      logic signed [PosW-1:0] position;
      logic                   use_typed;
      drive_cmd_type          typed;
   } stim_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_MOSTLY
   } ready_style_type;

   // Button masks, bit order as on the request bus
   localparam logic [3:0] BtnNone  = 4'b0000;
   localparam logic [3:0] BtnUp    = 4'b0001;
   localparam logic [3:0] BtnDown  = 4'b0010;
   localparam logic [3:0] BtnLeft  = 4'b0100;
   localparam logic [3:0] BtnRight = 4'b1000;
   localparam logic [3:0] BtnAll   = 4'b1111;

   localparam logic signed [PosW-1:0] PosMax  = 16'sh7FFF;
   localparam logic signed [PosW-1:0] PosMin  = 16'sh8000;
   localparam logic signed [PosW-1:0] PosZero = 16'sd0;
   localparam logic [GainW-1:0]       GainMax = 24'hFFFFFF;
   localparam logic [GainW-1:0]       GainOff = 24'h000000;

   // Register presets after reset
   localparam logic [GainW-1:0]       RstGainP  = 24'd32768;
   localparam logic [GainW-1:0]       RstGainI  = 24'd66;
   localparam logic [GainW-1:0]       RstGainD  = 24'd66;
   localparam logic signed [PosW-1:0] RstHigh   = 16'sd690;
   localparam logic signed [PosW-1:0] RstCarry  = 16'sd550;
   localparam logic signed [PosW-1:0] RstLow    = 16'sd15;

   // Indexes past the register file; writes there must be ignored
   localparam logic [CsrAddrW-1:0] CsrSpareLo = 3'd6;
   localparam logic [CsrAddrW-1:0] CsrSpareHi = 3'd7;

   localparam logic signed [VelW-1:0] VelMax = VelW'(VelLimit);
   localparam logic signed [VelW-1:0] VelMin = -VelW'(VelLimit);
   localparam longint SumMax = (longint'(1) <<< (SumW - 1)) - 1;
   localparam longint SumMin = -(longint'(1) <<< (SumW - 1));
   localparam longint QScale = longint'(1) <<< FracW;

   localparam drive_cmd_type IdleCmd = '{'0, 1'b0, MODE_NONE};
   localparam drive_cmd_type StopCmd = '{'0, 1'b1, MODE_STOP};
   localparam drive_cmd_type FullUp  = '{VelMax, 1'b1, MODE_HIGH};
   localparam drive_cmd_type FullDn  = '{VelMin, 1'b1, MODE_HIGH};

   localparam int DirectedCount   = 19;
   localparam int SettleCycles    = 4;
   localparam int LongStallCycles = 300;
   localparam int DrainLimit      = 20000;
   localparam int CycleLimit      = 5000000;
   // Requests per leg of the integral sweep; a leg moves it by 65535 per tick
   localparam int SweepLeg        = 10;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we;
   logic [CsrAddrW-1:0] csr_addr;
   logic [CsrDataW-1:0] csr_wdata;

   // Shadow configuration and controller state
   cfg_type                lift_cfg;
   mode_type               held_mode;
   logic signed [SumW-1:0] integral;
   logic signed [ErrW-1:0] prev_error;

   drive_cmd_type drive_expect_q [$];
   stim_row_type  directed_rows [DirectedCount];
   logic          typed_expect_valid;
   drive_cmd_type typed_expect;
   int            burst_left;
   int            long_stall_asked;
   int            mismatch_count;
   int            cycle_count;

   preset_position_pid dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Latch the mode, run one PID step where a preset is active
   function automatic drive_cmd_type predict_drive(input logic [3:0] buttons,
                                                   input logic signed [PosW-1:0] position);
      drive_cmd_type          cmd;
      logic signed [PosW-1:0] target;
      logic                   run_pid;
      longint                 err;
      longint                 sum;
      longint                 deriv;
      longint                 acc;
      longint                 whole;
      if (buttons[0]) held_mode = MODE_HIGH;
      else if (buttons[1]) held_mode = MODE_LOW;
      else if (buttons[2]) held_mode = MODE_CARRY;
      else if (buttons[3]) held_mode = MODE_STOP;
      cmd.velocity = '0;
      cmd.enable   = (held_mode != MODE_NONE);
      cmd.mode     = held_mode;
      run_pid      = 1'b1;
      target       = '0;
      case (held_mode)
         MODE_HIGH:  target = lift_cfg.target_high;
         MODE_LOW:   target = lift_cfg.target_low;
         MODE_CARRY: target = lift_cfg.target_carry;
         default:    run_pid = 1'b0;
      endcase
      if (run_pid) begin
         err = longint'(target) - longint'(position);
         sum = longint'(integral) + err;
         if (sum > SumMax) sum = SumMax;
         if (sum < SumMin) sum = SumMin;
         integral   = SumW'(sum);
         deriv      = err - longint'(prev_error);
         prev_error = ErrW'(err);
         acc = longint'(lift_cfg.gain_p) * err
             + longint'(lift_cfg.gain_i) * sum
             + longint'(lift_cfg.gain_d) * deriv;
         // integer division drops the fraction toward zero
         whole = acc / QScale;
         if (whole > VelLimit) whole = VelLimit;
         if (whole < -VelLimit) whole = -VelLimit;
         cmd.velocity = VelW'(whole);
      end
      return cmd;
   endfunction

   // Predict on accepted requests first, then check accepted results
   always @(posedge clock) begin
      drive_cmd_type predicted;
      drive_cmd_type seen;
      drive_cmd_type want;
      if (!reset && req_tvalid && req_tready) begin
         predicted = predict_drive(req_tdata[3:0], req_tdata[PosW+3:4]);
         drive_expect_q.push_back(typed_expect_valid ? typed_expect : predicted);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.velocity = rsp_tdata[VelW-1:0];
         seen.enable   = rsp_tdata[VelW];
         seen.mode     = mode_type'(rsp_tdata[VelW+3:VelW+1]);
         if (drive_expect_q.size() == 0) begin
            $error("result with no request waiting: velocity %0d enable %0d mode %0d",
                   seen.velocity, seen.enable, seen.mode);
            mismatch_count++;
         end else begin
            want = drive_expect_q.pop_front();
            if (seen.velocity !== want.velocity) begin
               $error("drive_velocity: expected %0d, got %0d", want.velocity, seen.velocity);
               mismatch_count++;
            end
            if (seen.enable !== want.enable) begin
               $error("drive_enable: expected %0d, got %0d", want.enable, seen.enable);
               mismatch_count++;
            end
            if (seen.mode !== want.mode) begin
               $error("active_mode: expected %0d, got %0d", want.mode, seen.mode);
               mismatch_count++;
            end
         end
      end
   end

   // Stall the result side in changing styles; honor long hold-off requests
   initial begin
      ready_style_type style;
      int              style_left;
      int              stall_left;
      int              stall_done;
      rsp_tready = 1'b0;
      style      = READY_ALWAYS;
      style_left = 0;
      stall_left = 0;
      stall_done = 0;
      forever begin
         @(negedge clock);
         if (long_stall_asked != stall_done) begin
            stall_done = long_stall_asked;
            stall_left = LongStallCycles;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = ready_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(8, 64);
            end
            style_left--;
            case (style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready <= (style_left % 4 == 0);
               default:      rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offer one request in bursts with random gaps; return once it is taken
   task automatic send_request(input logic [3:0] buttons,
                               input logic signed [PosW-1:0] position,
                               input logic use_typed,
                               input drive_cmd_type typed);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid         <= 1'b1;
      req_tdata          <= {{(ReqDataW - PosW - 4){1'b0}}, position, buttons};
      typed_expect_valid  = use_typed;
      typed_expect        = typed;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold requests until every result is back
   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left  = 0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrAddrW-1:0] reg_index,
                            input logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= reg_index;
      csr_wdata <= value;
      @(posedge clock);
      case (reg_index)
         CSR_GAIN_P:       lift_cfg.gain_p       = value;
         CSR_GAIN_I:       lift_cfg.gain_i       = value;
         CSR_GAIN_D:       lift_cfg.gain_d       = value;
         CSR_TARGET_HIGH:  lift_cfg.target_high  = value[PosW-1:0];
         CSR_TARGET_CARRY: lift_cfg.target_carry = value[PosW-1:0];
         CSR_TARGET_LOW:   lift_cfg.target_low   = value[PosW-1:0];
         default: ;
      endcase
   endtask

   // Drain, then rewrite every register and poke the unused indexes
   task automatic set_config(input logic [GainW-1:0] gp, input logic [GainW-1:0] gi,
                             input logic [GainW-1:0] gd, input logic signed [PosW-1:0] high,
                             input logic signed [PosW-1:0] carry,
                             input logic signed [PosW-1:0] low);
      drain_requests();
      write_csr(CSR_GAIN_P, gp);
      write_csr(CSR_GAIN_I, gi);
      write_csr(CSR_GAIN_D, gd);
      write_csr(CSR_TARGET_HIGH, CsrDataW'(high));
      write_csr(CSR_TARGET_CARRY, CsrDataW'(carry));
      write_csr(CSR_TARGET_LOW, CsrDataW'(low));
      write_csr(CsrSpareLo, CsrDataW'($urandom));
      write_csr(CsrSpareHi, CsrDataW'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly idle ticks near a preset target, some presses, some wild positions
   task automatic run_random_ticks(input int count, input int hold_at, input int pause_at);
      logic [3:0]             buttons;
      logic signed [PosW-1:0] position;
      logic signed [PosW-1:0] aim;
      int                     pick;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) long_stall_asked++;
         if (n == pause_at) drain_requests();
         buttons = ($urandom_range(0, 9) < 7) ? BtnNone : 4'($urandom_range(1, 15));
         case ($urandom_range(0, 2))
            0:       aim = lift_cfg.target_high;
            1:       aim = lift_cfg.target_low;
            default: aim = lift_cfg.target_carry;
         endcase
         pick = $urandom_range(0, 9);
         if (pick < 6) position = aim + PosW'($urandom_range(0, 1024) - 512);
         else if (pick < 8) position = PosW'($urandom);
         else if (pick == 8) position = PosMax;
         else position = PosMin;
         send_request(buttons, position, 1'b0, IdleCmd);
      end
   endtask

   task automatic sweep_integral(input logic [3:0] buttons,
                                 input logic signed [PosW-1:0] position, input int count);
      for (int n = 0; n < count; n++) send_request(buttons, position, 1'b0, IdleCmd);
   endtask

   initial begin
      int waited;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      csr_we             = 1'b0;
      csr_addr           = '0;
      csr_wdata          = '0;
      typed_expect_valid = 1'b0;
      typed_expect       = IdleCmd;
      burst_left         = 0;
      long_stall_asked   = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      lift_cfg           = '{RstGainP, RstGainI, RstGainD, RstHigh, RstCarry, RstLow};
      held_mode          = MODE_NONE;
      integral           = '0;
      prev_error         = '0;

      // Typed rows follow from reset state; the rest go through the model
      directed_rows = '{
         '{BtnNone,                     PosZero,      1'b1, IdleCmd},
         '{BtnNone,                     PosMax,       1'b1, IdleCmd},
         '{BtnNone,                     PosMin,       1'b1, IdleCmd},
         '{BtnRight,                    PosMin,       1'b1, StopCmd},
         '{BtnAll,                      PosMin,       1'b1, FullUp},
         '{BtnUp,                       PosMax,       1'b1, FullDn},
         '{BtnNone,                     RstHigh,      1'b0, IdleCmd},
         '{BtnDown,                     PosZero,      1'b0, IdleCmd},
         '{BtnDown | BtnLeft | BtnRight, RstLow,      1'b0, IdleCmd},
         '{BtnLeft,                     RstCarry,     1'b0, IdleCmd},
         '{BtnLeft | BtnRight,          -16'sd1,      1'b0, IdleCmd},
         '{BtnRight,                    16'sd100,     1'b1, StopCmd},
         '{BtnNone,                     -16'sd100,    1'b1, StopCmd},
         '{BtnDown,                     PosMin,       1'b0, IdleCmd},
         '{BtnUp | BtnDown,             16'sd689,     1'b0, IdleCmd},
         '{BtnLeft,                     PosMax,       1'b0, IdleCmd},
         '{BtnDown | BtnLeft | BtnRight, 16'sh5555,   1'b0, IdleCmd},
         '{BtnRight,                    16'shAAAA,    1'b1, StopCmd},
         '{BtnNone,                     PosMax,       1'b1, StopCmd}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_request(directed_rows[r].buttons, directed_rows[r].position,
                      directed_rows[r].use_typed, directed_rows[r].typed);

      // Presets rewritten, with a full drain partway through
      set_config(RstGainP, RstGainI, RstGainD, RstHigh, RstCarry, RstLow);
      run_random_ticks(100, -1, 50);

      // All gains off, targets at the range ends and at zero
      set_config(GainOff, GainOff, GainOff, PosMin, PosMax, PosZero);
      run_random_ticks(60, -1, -1);

      // All gains at full scale
      set_config(GainMax, GainMax, GainMax, PosMax, PosMin, PosMax);
      run_random_ticks(60, -1, -1);

      // Small gains so the drive stays mostly inside its limits; long hold-off
      set_config(GainW'($urandom_range(0, 'h3FF)), GainW'($urandom_range(0, 4)),
                 GainW'($urandom_range(0, 'h3FFF)), PosW'($urandom), PosW'($urandom),
                 PosW'($urandom));
      run_random_ticks(100, 10, -1);

      // Anything goes
      set_config(GainW'($urandom), GainW'($urandom_range(0, 'hFF)), GainW'($urandom),
                 PosW'($urandom), PosW'($urandom), PosW'($urandom));
      run_random_ticks(100, -1, -1);

      // Swing the integral up, down and back at the widest error
      set_config(GainOff, 24'd1, GainOff, PosMax, PosZero, PosMin);
      sweep_integral(BtnUp, PosMin, SweepLeg);
      sweep_integral(BtnDown, PosMax, 2 * SweepLeg);
      sweep_integral(BtnUp, PosMin, SweepLeg);

      // Integral stays large from here on; keep its gain off
      set_config(GainW'($urandom_range(0, 'h1FFFF)), GainOff,
                 GainW'($urandom_range(0, 'h1FFFF)), PosW'($urandom), PosW'($urandom),
                 PosW'($urandom));
      run_random_ticks(80, -1, -1);

      // Let the last results come back, then allow for strays
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (drive_expect_q.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (drive_expect_q.size() != 0)
         $error("%0d expected results never arrived", drive_expect_q.size());
      if (mismatch_count == 0 && drive_expect_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ppid_pkg.sv
rtl/ppid_csr.sv
rtl/ppid_pid.sv
rtl/preset_position_pid.sv
tb/sv/preset_position_pid_test.sv
